FILE: design/wsfr_pkg.sv
// Shared types and constants of the WebSocket frame receiver.
package wsfr_pkg;

    localparam int LENGTH_WIDTH = 64;

    localparam logic       OP_RESTART     = 1'b1;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_HEADER    = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;
    localparam logic [7:0] RSV_BITS       = 8'h70;
    localparam logic [2:0] OPCODE_LOW_MAX = 3'd2;
    localparam logic [6:0] LEN7_EXT16     = 7'd126;
    localparam logic [6:0] LEN7_EXT64     = 7'd127;
    localparam int         MASK_BYTES     = 4;
    localparam int         LEN64_BYTES    = 8;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_16,
        LEN_64
    } len_sel_t;

    typedef struct packed {
        logic       restart;
        logic       first_bad;
        len_sel_t   len_sel;
        logic [7:0] data_byte;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  opcode;
        logic        fin;
        logic        masked;
        logic [63:0] payload_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic push;
    } q_ctrl_t;

endpackage

FILE: design/wsfr_in_if.sv
// Input stream channel: valid, ready and the received item.
interface wsfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

FILE: design/wsfr_out_if.sv
// Result stream channel: valid, ready and the result item.
interface wsfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic        fin;
    logic        masked;
    logic [63:0] payload_length;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output opcode,
                    output fin, output masked, output payload_length, output last,
                    input ready);
    modport sink (input valid, input kind, input payload_byte, input opcode,
                  input fin, input masked, input payload_length, input last,
                  output ready);
endinterface

FILE: design/wsfr_front.sv
// Front end: accepts input transfers and classifies each byte.
module wsfr_front (
    wsfr_in_if.sink          rx,
    input  logic             q_full,
    output wsfr_pkg::q_ctrl_t q_ctrl,
    output wsfr_pkg::entry_t push_entry
);

    logic [6:0] len7;

    assign len7 = rx.data_byte[6:0];

    assign rx.ready     = !q_full;
    assign q_ctrl.push  = rx.valid && !q_full;

    always_comb
    begin
        push_entry.restart   = (rx.op == wsfr_pkg::OP_RESTART);
        push_entry.data_byte = rx.data_byte;
        push_entry.first_bad = ((rx.data_byte & wsfr_pkg::RSV_BITS) != 8'h00) ||
                               (rx.data_byte[2:0] > wsfr_pkg::OPCODE_LOW_MAX);
        unique case (len7)
            wsfr_pkg::LEN7_EXT16: push_entry.len_sel = wsfr_pkg::LEN_16;
            wsfr_pkg::LEN7_EXT64: push_entry.len_sel = wsfr_pkg::LEN_64;
            default:              push_entry.len_sel = wsfr_pkg::LEN_SHORT;
        endcase
    end

endmodule

FILE: design/wsfr_queue.sv
// Two-entry queue between the classifier and the parser.
module wsfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  wsfr_pkg::q_ctrl_t q_ctrl,
    input  wsfr_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output wsfr_pkg::entry_t  pop_entry
);

    wsfr_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = q_ctrl.push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, q_ctrl.push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (q_ctrl.push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/wsfr_back.sv
// Back end: frame header parser, unmasking and result register.
module wsfr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  wsfr_pkg::entry_t q_entry,
    output logic             pop,
    wsfr_out_if.source       res
);

    localparam int LW = wsfr_pkg::LENGTH_WIDTH;
    localparam logic [2:0] LEN64_LAST = 3'(wsfr_pkg::LEN64_BYTES - 1);
    localparam logic [1:0] MASK_LAST  = 2'(wsfr_pkg::MASK_BYTES - 1);

    typedef enum logic [3:0] {
        S_OPCODE,
        S_LEN8,
        S_LEN16_0,
        S_LEN16_1,
        S_LEN64,
        S_MASK,
        S_BODY,
        S_DONE,
        S_ERROR
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              mask_reg, mask_next;
    logic [7:0]        header_reg, header_next;
    logic [LW-1:0]     acc_reg, acc_next;
    logic [LW-1:0]     index_reg, index_next;
    logic [7:0]        key_reg [wsfr_pkg::MASK_BYTES];
    logic [7:0]        key_next [wsfr_pkg::MASK_BYTES];
    wsfr_pkg::result_t res_reg, res_next;
    logic              valid_reg, valid_next;

    logic              emit;
    logic              finish_len;
    logic              finish_hdr;
    logic [LW-1:0]     acc_or;
    logic [LW-1:0]     acc_shift;
    logic [LW-1:0]     index_inc;
    logic [7:0]        c;

    assign c         = q_entry.data_byte;
    assign pop       = q_valid && (!valid_reg || res.ready);
    assign acc_or    = acc_reg | LW'(c);
    assign acc_shift = {acc_or[LW-9:0], 8'h00};
    assign index_inc = index_reg + LW'(1);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mask_next   = mask_reg;
        header_next = header_reg;
        acc_next    = acc_reg;
        index_next  = index_reg;
        key_next    = key_reg;
        res_next    = res_reg;
        emit        = 1'b0;
        finish_len  = 1'b0;
        finish_hdr  = 1'b0;

        if (q_entry.restart)
        begin
            state_next = S_OPCODE;
        end
        else
        begin
            unique case (state_reg)
                S_OPCODE:
                begin
                    index_next = '0;
                    mask_next  = 1'b0;
                    if (q_entry.first_bad)
                    begin
                        state_next = S_ERROR;
                        emit       = 1'b1;
                        res_next   = '0;
                        res_next.kind   = wsfr_pkg::KIND_ERROR;
                        res_next.opcode = c[3:0];
                        res_next.fin    = c[7];
                    end
                    else
                    begin
                        header_next = c;
                        state_next  = S_LEN8;
                    end
                end
                S_LEN8:
                begin
                    mask_next = c[7];
                    acc_next  = '0;
                    cnt_next  = 3'd0;
                    case (q_entry.len_sel)
                        wsfr_pkg::LEN_16: state_next = S_LEN16_0;
                        wsfr_pkg::LEN_64: state_next = S_LEN64;
                        default:
                        begin
                            acc_next   = LW'(c[6:0]);
                            finish_len = 1'b1;
                        end
                    endcase
                end
                S_LEN16_0:
                begin
                    acc_next   = acc_shift;
                    state_next = S_LEN16_1;
                end
                S_LEN16_1:
                begin
                    acc_next   = acc_or;
                    finish_len = 1'b1;
                end
                S_LEN64:
                begin
                    if (cnt_reg == LEN64_LAST)
                    begin
                        acc_next   = acc_or;
                        finish_len = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                S_MASK:
                begin
                    key_next[cnt_reg[1:0]] = c;
                    if (cnt_reg[1:0] == MASK_LAST)
                    begin
                        finish_hdr = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                S_BODY:
                begin
                    index_next = index_inc;
                    emit       = 1'b1;
                    res_next.kind           = wsfr_pkg::KIND_PAYLOAD;
                    res_next.payload_byte   = c ^ key_reg[index_reg[1:0]];
                    res_next.opcode         = header_reg[3:0];
                    res_next.fin            = header_reg[7];
                    res_next.masked         = mask_reg;
                    res_next.payload_length = 64'(acc_reg);
                    res_next.last           = (index_inc == acc_reg);
                    if (index_inc == acc_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase

            if (finish_len)
            begin
                if (mask_next)
                begin
                    state_next = S_MASK;
                    cnt_next   = 3'd0;
                end
                else
                begin
                    for (int i = 0; i < wsfr_pkg::MASK_BYTES; i++)
                    begin
                        key_next[i] = 8'h00;
                    end
                    finish_hdr = 1'b1;
                end
            end

            if (finish_hdr)
            begin
                emit = 1'b1;
                res_next.kind           = wsfr_pkg::KIND_HEADER;
                res_next.payload_byte   = 8'h00;
                res_next.opcode         = header_next[3:0];
                res_next.fin            = header_next[7];
                res_next.masked         = mask_next;
                res_next.payload_length = 64'(acc_next);
                res_next.last           = (acc_next == '0);
                state_next = (acc_next == '0) ? S_DONE : S_BODY;
            end
        end

        valid_next = pop ? emit : (valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_OPCODE;
            cnt_reg    <= 3'd0;
            mask_reg   <= 1'b0;
            header_reg <= 8'h00;
            acc_reg    <= '0;
            index_reg  <= '0;
            for (int i = 0; i < wsfr_pkg::MASK_BYTES; i++)
            begin
                key_reg[i] <= 8'h00;
            end
            res_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg  <= state_next;
                cnt_reg    <= cnt_next;
                mask_reg   <= mask_next;
                header_reg <= header_next;
                acc_reg    <= acc_next;
                index_reg  <= index_next;
                key_reg    <= key_next;
                if (emit)
                begin
                    res_reg <= res_next;
                end
            end
            valid_reg <= valid_next;
        end
    end

    assign res.valid          = valid_reg;
    assign res.kind           = res_reg.kind;
    assign res.payload_byte   = res_reg.payload_byte;
    assign res.opcode         = res_reg.opcode;
    assign res.fin            = res_reg.fin;
    assign res.masked         = res_reg.masked;
    assign res.payload_length = res_reg.payload_length;
    assign res.last           = res_reg.last;

endmodule

FILE: design/websocket_frame_receiver_unit.sv
// Top level of the WebSocket frame receiver.
// Takes one stream byte or restart per cycle and sustains one item per cycle unless
// the result stalls: a classifier accepts the transfer into a two-entry queue, and
// the parser takes one queue entry per cycle into a single result register, so a
// stalled result blocks the parser only once that register is full and input only
// once the queue fills. Bytes go via a queue slot to the result register. Restarts,
// non-final header bytes and bytes after frame end or a protocol error give no
// result; a header result gives opcode, fin, mask, length; body bytes are unmasked.
module websocket_frame_receiver_unit (
    input  logic       clk,
    input  logic       rst_n,
    wsfr_in_if.sink    rx,
    wsfr_out_if.source res
);

    wsfr_pkg::q_ctrl_t q_ctrl;
    wsfr_pkg::entry_t  push_entry;
    wsfr_pkg::entry_t  pop_entry;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    wsfr_front u_front (
        .rx         (rx),
        .q_full     (q_full),
        .q_ctrl     (q_ctrl),
        .push_entry (push_entry)
    );

    wsfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_ctrl     (q_ctrl),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    wsfr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (pop_entry),
        .pop     (q_pop),
        .res     (res)
    );

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == wsfr_pkg::KIND_ERROR |->
        res.payload_length == 64'd0 && !res.masked && !res.last &&
        res.payload_byte == 8'h00)
    else $error("error result carries frame fields");

    a_empty_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == wsfr_pkg::KIND_HEADER && res.last |->
        res.payload_length == 64'd0)
    else $error("header result flagged last with nonzero length");

    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == wsfr_pkg::KIND_PAYLOAD |->
        res.payload_length != 64'd0)
    else $error("payload byte emitted for zero-length frame");

    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.push |-> !q_full)
    else $error("push into full queue");

endmodule
